>>> sv/mtql_pkg.sv
// ----------------------------------------------------------------------------
// mtql_pkg
// Shared types, codes and defaults of the multitask Q-learning step core.
// ----------------------------------------------------------------------------
package mtql_pkg;

  localparam int DEF_MAX_STATES  = 256;
  localparam int DEF_MAX_ACTIONS = 8;
  localparam int DEF_MAX_TASKS   = 4;

  localparam logic [8:0]  RST_NUM_STATES   = 9'd256;
  localparam logic [3:0]  RST_NUM_ACTIONS  = 4'd8;
  localparam logic [2:0]  RST_NUM_TASKS    = 3'd4;
  localparam logic [15:0] RST_LEARN_RATE   = 16'd32768;
  localparam logic [15:0] RST_DISCOUNT     = 16'd58982;
  localparam logic [9:0]  RST_EXPLORE      = 10'd300;
  localparam logic [9:0]  EXPLORE_FLOOR    = 10'd5;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    FUNC_WR_TRANS  = 3'd0,
    FUNC_WR_REWARD = 3'd1,
    FUNC_RD_Q      = 3'd2,
    FUNC_START     = 3'd3,
    FUNC_MOVE      = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_MOVED    = 3'd1,
    STAT_REDRAW   = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_GOAL     = 3'd4,
    STAT_NO_EPIS  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_NUM_STATES  = 3'd0,
    REG_NUM_ACTIONS = 3'd1,
    REG_NUM_TASKS   = 3'd2,
    REG_LEARN_RATE  = 3'd3,
    REG_DISCOUNT    = 3'd4,
    REG_EXPLORE     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRD,
    ST_GOAL_SCAN,
    ST_SCAN,
    ST_PICK,
    ST_TRANS,
    ST_TCHK,
    ST_MAX,
    ST_CUR,
    ST_MUL1,
    ST_DIFF,
    ST_MUL2,
    ST_WRITE,
    ST_RESP
  } mtql_state_t;

endpackage

>>> sv/mtql_if.sv
// ----------------------------------------------------------------------------
// mtql_if
// Request, response and configuration channels of the Q-learning step core.
// ----------------------------------------------------------------------------
interface mtql_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  state_index;
  logic [2:0]  action_index;
  logic [1:0]  task_index;
  logic signed [8:0]  next_state;
  logic signed [31:0] reward_value;
  logic [15:0] explore_draw;
  logic [15:0] pick_draw;

  modport source (output valid, func, state_index, action_index, task_index, next_state,
                  reward_value, explore_draw, pick_draw, input ready);
  modport sink   (input valid, func, state_index, action_index, task_index, next_state,
                  reward_value, explore_draw, pick_draw, output ready);
endinterface

interface mtql_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  current_state;
  logic [2:0]  chosen_action;
  logic signed [31:0] q_value;

  modport source (output valid, status, current_state, chosen_action, q_value, input ready);
  modport sink   (input valid, status, current_state, chosen_action, q_value, output ready);
endinterface

interface mtql_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mtql_ram.sv
// ----------------------------------------------------------------------------
// mtql_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/multitask_q_learning_step_core.sv
// ----------------------------------------------------------------------------
// multitask_q_learning_step_core
// Multi-task tabular Q-learning engine with epsilon-greedy action choice.
// ----------------------------------------------------------------------------
// After reset the Q memory is swept to zero, one entry a cycle, through all
// MAX_TASKS*MAX_STATES*MAX_ACTIONS entries (8192 by default); no item is
// taken meanwhile, configuration writes are. Items are handled one at a time,
// and every Q, transition and reward access goes through memories with one
// read and one write port. A move runs a greedy scan (skipped when exploring
// or redrawing), then a transition check, update and response, each
// task scanning its destination row for max Q before a two-multiplier
// read-modify-write of its own entry. A move that hits an unavailable
// action stops after the transition check. The result sits in an output
// register, so a stalled response holds off only the end of the next item.
// ----------------------------------------------------------------------------
module multitask_q_learning_step_core
  import mtql_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_ACTIONS = DEF_MAX_ACTIONS,
  parameter int MAX_TASKS   = DEF_MAX_TASKS
) (
  input  logic       clk,
  input  logic       rst,
  mtql_req_if.sink   req,
  mtql_rsp_if.source rsp,
  mtql_cfg_if.sink   cfg
);

  localparam int SW   = $clog2(MAX_STATES);
  localparam int AW   = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int TW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int QD   = MAX_TASKS * MAX_STATES * MAX_ACTIONS;
  localparam int TD   = MAX_STATES * MAX_ACTIONS;
  localparam int RD   = MAX_STATES * MAX_TASKS;
  localparam int QAW  = $clog2(QD);
  localparam int TAW  = $clog2(TD);
  localparam int RAW  = $clog2(RD);

  function automatic logic [QAW-1:0] q_addr(logic [TW-1:0] t, logic [SW-1:0] s,
                                            logic [AW-1:0] a);
    q_addr = QAW'((32'(t) * MAX_STATES + 32'(s)) * MAX_ACTIONS + 32'(a));
  endfunction

  function automatic logic [TAW-1:0] t_addr(logic [SW-1:0] s, logic [AW-1:0] a);
    t_addr = TAW'(32'(s) * MAX_ACTIONS + 32'(a));
  endfunction

  function automatic logic [RAW-1:0] r_addr(logic [SW-1:0] s, logic [TW-1:0] t);
    r_addr = RAW'(32'(s) * MAX_TASKS + 32'(t));
  endfunction

  mtql_state_t state, state_next;

  logic [QAW-1:0] clr_cnt;
  logic [8:0]  num_states;
  logic [3:0]  num_actions;
  logic [2:0]  num_tasks;
  logic [15:0] alpha_rate;
  logic [15:0] discount;
  logic [9:0]  explore_level;
  logic [SW-1:0] agent;
  logic episode_active;
  logic random_pending;

  logic [15:0] pick_hold;
  logic [AW-1:0] act;
  logic [SW-1:0] dest;
  logic [TW-1:0] tcnt;
  logic [AW-1:0] acnt;
  logic issuing;
  logic pend;
  logic pend_last;
  logic [AW-1:0] pend_a;
  logic goal;
  logic signed [31:0] best;
  logic signed [31:0] cur;
  logic signed [31:0] rew;
  logic signed [48:0] prod1;
  logic signed [34:0] diff;
  logic signed [51:0] prod2;
  status_t res_status;
  logic [2:0]  res_act;
  logic signed [31:0] res_q;

  logic rsp_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_state;
  logic [2:0]  out_act;
  logic signed [31:0] out_q;

  logic [8:0] ns_c;
  logic [3:0] na_c;
  logic [2:0] nt_c;
  logic last_a, last_t;
  logic req_fire;
  logic explore_hit;
  logic [AW-1:0] rnd_req, rnd_hold;
  logic [SW-1:0] start_pos;
  logic in_rng_q;
  logic trans_bad;
  logic goal_any;
  logic signed [48:0] p1r;
  logic signed [51:0] p2r;
  logic signed [36:0] qsum;
  logic signed [31:0] qsat;

  logic q_we, t_we, r_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic signed [31:0] q_wdata, q_rdata;
  logic [8:0]  t_rdata;
  logic signed [31:0] r_rdata;
  logic rsp_load;

  mtql_ram #(.WIDTH(32), .DEPTH(QD)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  mtql_ram #(.WIDTH(9), .DEPTH(TD)) u_trans_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(req.next_state), .raddr(t_raddr),
    .rdata(t_rdata)
  );

  mtql_ram #(.WIDTH(32), .DEPTH(RD)) u_reward_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(req.reward_value), .raddr(r_raddr),
    .rdata(r_rdata)
  );

  always_comb begin
    ns_c = (num_states == 9'd0) ? 9'd1 :
           ((32'(num_states) > MAX_STATES) ? 9'(MAX_STATES) : num_states);
    na_c = (num_actions == 4'd0) ? 4'd1 :
           ((32'(num_actions) > MAX_ACTIONS) ? 4'(MAX_ACTIONS) : num_actions);
    nt_c = (num_tasks == 3'd0) ? 3'd1 :
           ((32'(num_tasks) > MAX_TASKS) ? 3'(MAX_TASKS) : num_tasks);
    last_a = (32'(acnt) + 1 == 32'(na_c));
    last_t = (32'(tcnt) + 1 == 32'(nt_c));
    req_fire = req.valid && req.ready;
    explore_hit = (32'(req.explore_draw) * 32'd100) < (32'(explore_level) << 16);
    rnd_req = AW'((20'(req.pick_draw) * 20'(na_c)) >> 16);
    rnd_hold = AW'((20'(pick_hold) * 20'(na_c)) >> 16);
    start_pos = SW'((25'(req.pick_draw) * 25'(ns_c)) >> 16);
    in_rng_q = (32'(req.state_index) < MAX_STATES) && (32'(req.action_index) < MAX_ACTIONS)
               && (32'(req.task_index) < MAX_TASKS);
    trans_bad = t_rdata[8] || (t_rdata >= ns_c);
    goal_any = goal || (r_rdata != 32'sd0);
    p1r = prod1 + 49'sd32768;
    p2r = prod2 + 52'sd32768;
    qsum = 37'(cur) + 37'($signed(p2r[51:16]));
    if (qsum > 37'(Q_MAX)) begin
      qsat = Q_MAX;
    end else if (qsum < 37'(Q_MIN)) begin
      qsat = Q_MIN;
    end else begin
      qsat = 32'(qsum);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (32'(clr_cnt) == QD - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (req.func)
            FUNC_RD_Q:  state_next = in_rng_q ? ST_QRD : ST_RESP;
            FUNC_START: state_next = ST_GOAL_SCAN;
            FUNC_MOVE: begin
              if (!episode_active) begin
                state_next = ST_RESP;
              end else if (random_pending || explore_hit) begin
                state_next = ST_TRANS;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_QRD:       state_next = ST_RESP;
      ST_GOAL_SCAN: if (pend && pend_last) state_next = ST_RESP;
      ST_SCAN:      if (pend && pend_last) state_next = ST_PICK;
      ST_PICK:      state_next = ST_TRANS;
      ST_TRANS:     state_next = ST_TCHK;
      ST_TCHK:      state_next = trans_bad ? ST_RESP : ST_MAX;
      ST_MAX:       if (pend && pend_last) state_next = ST_CUR;
      ST_CUR:       state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_WRITE;
      ST_WRITE:     state_next = last_t ? ST_RESP : ST_MAX;
      ST_RESP:      if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    cfg.ready = 1'b1;
    rsp.valid = rsp_valid;
    rsp.status = out_status;
    rsp.current_state = out_state;
    rsp.chosen_action = out_act;
    rsp.q_value = out_q;
    rsp_load = (state == ST_RESP) && (!rsp_valid || rsp.ready);
    q_we = 1'b0;
    q_waddr = clr_cnt;
    q_wdata = 32'sd0;
    q_raddr = '0;
    t_we = 1'b0;
    t_waddr = t_addr(SW'(req.state_index), AW'(req.action_index));
    t_raddr = t_addr(agent, act);
    r_we = 1'b0;
    r_waddr = r_addr(SW'(req.state_index), TW'(req.task_index));
    r_raddr = '0;
    case (state)
      ST_CLEAR: q_we = 1'b1;
      ST_IDLE: begin
        q_raddr = q_addr(TW'(req.task_index), SW'(req.state_index), AW'(req.action_index));
        t_we = req_fire && (req.func == FUNC_WR_TRANS) &&
               (32'(req.state_index) < MAX_STATES) && (32'(req.action_index) < MAX_ACTIONS);
        r_we = req_fire && (req.func == FUNC_WR_REWARD) &&
               (32'(req.state_index) < MAX_STATES) && (32'(req.task_index) < MAX_TASKS);
      end
      ST_GOAL_SCAN: r_raddr = r_addr(dest, tcnt);
      ST_SCAN:      q_raddr = q_addr(tcnt, agent, acnt);
      ST_MAX:       q_raddr = q_addr(tcnt, dest, acnt);
      ST_CUR: begin
        q_raddr = q_addr(tcnt, agent, act);
        r_raddr = r_addr(dest, tcnt);
      end
      ST_WRITE: begin
        q_we = 1'b1;
        q_waddr = q_addr(tcnt, agent, act);
        q_wdata = qsat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      num_states <= RST_NUM_STATES;
      num_actions <= RST_NUM_ACTIONS;
      num_tasks <= RST_NUM_TASKS;
      alpha_rate <= RST_LEARN_RATE;
      discount <= RST_DISCOUNT;
      explore_level <= RST_EXPLORE;
      agent <= '0;
      episode_active <= 1'b0;
      random_pending <= 1'b0;
      rsp_valid <= 1'b0;
      issuing <= 1'b0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NUM_STATES:  num_states <= cfg.data[8:0];
          REG_NUM_ACTIONS: num_actions <= cfg.data[3:0];
          REG_NUM_TASKS:   num_tasks <= cfg.data[2:0];
          REG_LEARN_RATE:  alpha_rate <= cfg.data;
          REG_DISCOUNT:    discount <= cfg.data;
          REG_EXPLORE:     explore_level <= cfg.data[9:0];
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        out_status <= res_status;
        out_state <= 8'(agent);
        out_act <= res_act;
        out_q <= res_q;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (req_fire) begin
            res_status <= STAT_DONE;
            res_act <= 3'd0;
            res_q <= 32'sd0;
            pick_hold <= req.pick_draw;
            tcnt <= '0;
            acnt <= '0;
            pend <= 1'b0;
            goal <= 1'b0;
            best <= Q_MIN;
            issuing <= 1'b1;
            dest <= start_pos;
            if (req.func == FUNC_MOVE) begin
              if (!episode_active) begin
                res_status <= STAT_NO_EPIS;
              end else if (random_pending) begin
                act <= rnd_req;
              end else if (explore_hit) begin
                act <= rnd_req;
                if (explore_level > EXPLORE_FLOOR) explore_level <= explore_level - 1'b1;
              end
            end
          end
        end
        ST_QRD: res_q <= q_rdata;
        ST_GOAL_SCAN, ST_SCAN, ST_MAX: begin
          if (issuing) begin
            pend <= 1'b1;
            pend_a <= acnt;
            if (state == ST_MAX) begin
              pend_last <= last_a;
              acnt <= last_a ? '0 : acnt + 1'b1;
              if (last_a) issuing <= 1'b0;
            end else if (state == ST_GOAL_SCAN) begin
              pend_last <= last_t;
              tcnt <= tcnt + 1'b1;
              if (last_t) issuing <= 1'b0;
            end else begin
              pend_last <= last_a && last_t;
              if (last_a) begin
                acnt <= '0;
                tcnt <= tcnt + 1'b1;
              end else begin
                acnt <= acnt + 1'b1;
              end
              if (last_a && last_t) issuing <= 1'b0;
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (state == ST_GOAL_SCAN) begin
              goal <= goal_any;
              if (pend_last) begin
                if (goal_any) begin
                  res_status <= STAT_REJECTED;
                end else begin
                  agent <= dest;
                  episode_active <= 1'b1;
                  random_pending <= 1'b0;
                end
              end
            end else if (state == ST_SCAN) begin
              if (q_rdata >= best) begin
                best <= q_rdata;
                act <= pend_a;
              end
            end else if (q_rdata > best) begin
              best <= q_rdata;
            end
          end
          if (pend && pend_last && state != ST_MAX) begin
            tcnt <= '0;
          end
        end
        ST_PICK: begin
          if (best == 32'sd0) act <= rnd_hold;
        end
        ST_TCHK: begin
          res_act <= 3'(act);
          if (trans_bad) begin
            random_pending <= 1'b1;
            res_status <= STAT_REDRAW;
          end else begin
            random_pending <= 1'b0;
            dest <= SW'(t_rdata);
            tcnt <= '0;
            acnt <= '0;
            goal <= 1'b0;
            best <= Q_MIN;
            issuing <= 1'b1;
            pend <= 1'b0;
          end
        end
        ST_MUL1: begin
          cur <= q_rdata;
          rew <= r_rdata;
          goal <= goal_any;
          prod1 <= best * $signed({1'b0, discount});
        end
        ST_DIFF: diff <= 35'(rew) + 35'($signed(p1r[48:16])) - 35'(cur);
        ST_MUL2: prod2 <= diff * $signed({1'b0, alpha_rate});
        ST_WRITE: begin
          if (last_t) begin
            agent <= dest;
            if (goal) begin
              res_status <= STAT_GOAL;
              episode_active <= 1'b0;
            end else begin
              res_status <= STAT_MOVED;
            end
          end else begin
            tcnt <= tcnt + 1'b1;
            acnt <= '0;
            best <= Q_MIN;
            issuing <= 1'b1;
            pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_pending_in_episode: assert property (@(posedge clk) disable iff (rst)
    random_pending |-> episode_active)
    else $error("redraw pending outside an episode");

  a_q_write_phase: assert property (@(posedge clk) disable iff (rst)
    q_we |-> (state == ST_WRITE || state == ST_CLEAR))
    else $error("Q write outside update or clear");

  a_goal_ends_episode: assert property (@(posedge clk) disable iff (rst)
    rsp_load && res_status == STAT_GOAL |=> !episode_active)
    else $error("goal beat left the episode open");

endmodule
